// ===== hw/rtl/tam_pkg.sv =====
// shared types and constants for the three-axis moving-average filter
package tam_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int NUM_AXES       = 3;
    localparam int DEF_WINDOW_LEN = 12;
    // unsigned quotient magnitude, one bit wider than a sample to hold 32768
    localparam int QUOT_W         = SAMPLE_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== hw/rtl/tam_if.sv =====
// valid/ready channels for raw samples and window averages

interface tam_in_if;
    import tam_pkg::*;

    logic    valid;
    logic    ready;
    sample_t x_raw;
    sample_t y_raw;
    sample_t z_raw;

    modport source (output valid, output x_raw, output y_raw, output z_raw, input ready);
    modport sink   (input valid, input x_raw, input y_raw, input z_raw, output ready);
endinterface

interface tam_out_if;
    import tam_pkg::*;

    logic    valid;
    logic    ready;
    sample_t x_avg;
    sample_t y_avg;
    sample_t z_avg;

    modport source (output valid, output x_avg, output y_avg, output z_avg, input ready);
    modport sink   (input valid, input x_avg, input y_avg, input z_avg, output ready);
endinterface

// ===== hw/rtl/tam_ram.sv =====
// generic single-write, single-read ram with registered read data
module tam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/three_axis_moving_average.sv =====
// top level of the three-axis boxcar moving-average filter
//
// takes one x/y/z raw sample per transaction and returns one transaction with the
// three window averages (running sum of the last WINDOW_LEN samples divided by
// WINDOW_LEN, truncated toward zero). the sample history lives in one ram word
// per ring slot holding all three axes; it reads as zero after reset through a
// per-slot valid bit, so there is no clearing pass and the block is ready right
// out of reset. throughput is one transaction per clock as long as the output is not
// stalled; an accepted input passes through registered stages for ram read, sum
// update, magnitude, reciprocal multiply, and quotient and sign. each stage only
// holds when the one after it is full and stalled, so input keeps flowing while a
// finished result waits in the output register.
module three_axis_moving_average #(
    parameter int WINDOW_LEN = tam_pkg::DEF_WINDOW_LEN
) (
    input  logic      clk,
    input  logic      rst_n,
    tam_in_if.sink    samples,
    tam_out_if.source averages
);
    import tam_pkg::*;

    localparam int CLOG_N   = $clog2(WINDOW_LEN);
    localparam int SLOT_W   = (WINDOW_LEN > 1) ? CLOG_N : 1;
    localparam int SUM_W    = SAMPLE_W + CLOG_N;
    // reciprocal divide: q = (|s| * ceil(2^K / N)) >> K is exact for |s| < 2^SUM_W
    localparam int K        = SUM_W + CLOG_N;
    localparam int RECIP_W  = K + 2 - CLOG_N;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int MEM_W    = NUM_AXES * SAMPLE_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << K) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(32768 * WINDOW_LEN);

    // stage enables: a stage moves when it is empty or its successor moves
    logic en_out, en4, en3, en2, en1;
    logic acc, mv1;

    // ring write pointer and per-slot valid bits
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [WINDOW_LEN-1:0] vld_reg;

    // stage 1: sample waiting for its oldest entry from the ram
    logic              s1_v_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    sample_t           s1_smp_reg [NUM_AXES];
    logic              s1_fwd_reg;
    sample_t           s1_fwd_data_reg [NUM_AXES];
    logic              s1_hit_reg;

    // running sums
    logic signed [SUM_W-1:0] sum_reg  [NUM_AXES];
    logic signed [SUM_W-1:0] sum_next [NUM_AXES];

    // stage 2..4 and output
    logic                    s2_v_reg;
    logic signed [SUM_W-1:0] s2_sum_reg [NUM_AXES];
    logic                    s3_v_reg;
    logic [SUM_W-1:0]        s3_mag_reg [NUM_AXES];
    logic                    s3_neg_reg [NUM_AXES];
    logic                    s4_v_reg;
    logic [PROD_W-1:0]       s4_prod_reg [NUM_AXES];
    logic                    s4_neg_reg [NUM_AXES];
    logic                    out_v_reg;
    sample_t                 out_avg_reg [NUM_AXES];

    logic [MEM_W-1:0] rd_data;
    logic [MEM_W-1:0] wr_data;
    sample_t          in_smp [NUM_AXES];
    sample_t          oldest [NUM_AXES];

    assign en_out = !out_v_reg || averages.ready;
    assign en4    = !s4_v_reg || en_out;
    assign en3    = !s3_v_reg || en4;
    assign en2    = !s2_v_reg || en3;
    assign en1    = !s1_v_reg || en2;
    assign acc    = samples.valid && en1;
    assign mv1    = s1_v_reg && en2;

    assign samples.ready  = en1;
    assign averages.valid = out_v_reg;
    assign averages.x_avg = out_avg_reg[0];
    assign averages.y_avg = out_avg_reg[1];
    assign averages.z_avg = out_avg_reg[2];

    assign in_smp[0] = samples.x_raw;
    assign in_smp[1] = samples.y_raw;
    assign in_smp[2] = samples.z_raw;

    assign wr_data = {s1_smp_reg[2], s1_smp_reg[1], s1_smp_reg[0]};

    // sample history, all three axes in one word per slot
    tam_ram #(
        .WIDTH (MEM_W),
        .DEPTH (WINDOW_LEN),
        .ADDR_W(SLOT_W)
    ) u_ring (
        .clk    (clk),
        .wr_en  (mv1),
        .wr_addr(s1_slot_reg),
        .wr_data(wr_data),
        .rd_en  (acc),
        .rd_addr(slot_reg),
        .rd_data(rd_data)
    );

    always_comb
    begin
        slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
    end

    // oldest entry: forwarded write, ram data, or zero for a never-written slot
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (s1_fwd_reg)
            begin
                oldest[a] = s1_fwd_data_reg[a];
            end
            else if (s1_hit_reg)
            begin
                oldest[a] = rd_data[a*SAMPLE_W +: SAMPLE_W];
            end
            else
            begin
                oldest[a] = '0;
            end
            sum_next[a] = sum_reg[a] + SUM_W'(s1_smp_reg[a]) - SUM_W'(oldest[a]);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            vld_reg   <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            if (acc)
            begin
                slot_reg <= slot_next;
            end
            if (mv1)
            begin
                vld_reg[s1_slot_reg] <= 1'b1;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    sum_reg[a] <= sum_next[a];
                end
            end
            if (en1)
            begin
                s1_v_reg <= samples.valid;
            end
            if (en2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (en3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (en4)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (en_out)
            begin
                out_v_reg <= s4_v_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_slot_reg <= slot_reg;
            // same-slot write at the read edge only happens for a one-entry window
            s1_fwd_reg  <= mv1 && (s1_slot_reg == slot_reg);
            s1_hit_reg  <= vld_reg[slot_reg];
            for (int a = 0; a < NUM_AXES; a++)
            begin
                s1_smp_reg[a]      <= in_smp[a];
                s1_fwd_data_reg[a] <= s1_smp_reg[a];
            end
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (en2)
            begin
                s2_sum_reg[a] <= sum_next[a];
            end
            if (en3)
            begin
                s3_neg_reg[a] <= s2_sum_reg[a][SUM_W-1];
                s3_mag_reg[a] <= s2_sum_reg[a][SUM_W-1] ? SUM_W'(-s2_sum_reg[a])
                                                        : SUM_W'(s2_sum_reg[a]);
            end
            if (en4)
            begin
                s4_neg_reg[a]  <= s3_neg_reg[a];
                s4_prod_reg[a] <= PROD_W'(s3_mag_reg[a]) * PROD_W'(RECIP);
            end
            if (en_out)
            begin
                out_avg_reg[a] <= s4_neg_reg[a]
                    ? SAMPLE_W'(-s4_prod_reg[a][K +: QUOT_W])
                    : SAMPLE_W'(s4_prod_reg[a][K +: QUOT_W]);
            end
        end
    end

    // ring pointer never leaves the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("write slot out of range");

    // the slot written back reads as valid from the next cycle on
    a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
        mv1 |=> vld_reg[$past(s1_slot_reg)])
        else $error("valid bit not set after write-back");

    // an input can only stall when every stage and the output register are full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (s1_v_reg && s2_v_reg && s3_v_reg && s4_v_reg && out_v_reg))
        else $error("input stalled with a free stage");

    // each running sum stays within the window's bound
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_chk
        a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
            ((SUM_W + 1)'(sum_reg[g]) <= SUM_MAX) && ((SUM_W + 1)'(sum_reg[g]) >= -SUM_MAX))
            else $error("running sum out of bounds");
    end

endmodule

// ===== tb/sv/tam_avg_checker.sv =====
// checker for the three-axis moving-average filter: predicts window averages and compares
module tam_avg_checker #(
    parameter int WINDOW_LEN = tam_pkg::DEF_WINDOW_LEN
) (
    input  logic clk,
    input  logic rst_n,
    tam_in_if    samples,
    tam_out_if   averages,
    output int   fail_count,
    output int   pending,
    output int   checked
);
    import tam_pkg::*;

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t z;
    } avg_triplet_t;

    sample_t      hist [NUM_AXES][WINDOW_LEN];
    int           win_sum [NUM_AXES];
    int unsigned  next_slot;
    avg_triplet_t expected_avgs [$];

    // one window update over all three axes, returns the new averages
    function automatic avg_triplet_t boxcar_step(input sample_t sx, input sample_t sy,
                                                 input sample_t sz);
        sample_t      s [NUM_AXES];
        sample_t      q [NUM_AXES];
        int unsigned  slot;
        avg_triplet_t res;
        s[0] = sx;
        s[1] = sy;
        s[2] = sz;
        slot = (next_slot >= WINDOW_LEN) ? 0 : next_slot;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            win_sum[a] = win_sum[a] + int'(s[a]) - int'(hist[a][slot]);
            hist[a][slot] = s[a];
            // int division truncates toward zero
            q[a] = sample_t'(win_sum[a] / WINDOW_LEN);
        end
        next_slot = (slot + 1 >= WINDOW_LEN) ? 0 : slot + 1;
        res.x = q[0];
        res.y = q[1];
        res.z = q[2];
        return res;
    endfunction

    task automatic report_error(input string msg);
        fail_count++;
        if (fail_count <= 20)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        avg_triplet_t want;
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                win_sum[a] = 0;
                for (int i = 0; i < WINDOW_LEN; i++)
                    hist[a][i] = '0;
            end
            next_slot = 0;
            expected_avgs.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
                expected_avgs.push_back(boxcar_step(samples.x_raw, samples.y_raw,
                                                    samples.z_raw));
            if (averages.valid && averages.ready)
            begin
                if (expected_avgs.size() == 0)
                    report_error("output transaction with no expected averages");
                else
                begin
                    want = expected_avgs.pop_front();
                    if (averages.x_avg !== want.x)
                        report_error($sformatf("result %0d x_avg got %0d expected %0d",
                                               checked, averages.x_avg, want.x));
                    if (averages.y_avg !== want.y)
                        report_error($sformatf("result %0d y_avg got %0d expected %0d",
                                               checked, averages.y_avg, want.y));
                    if (averages.z_avg !== want.z)
                        report_error($sformatf("result %0d z_avg got %0d expected %0d",
                                               checked, averages.z_avg, want.z));
                    checked++;
                end
            end
            pending = expected_avgs.size();
        end
    end

endmodule

// ===== tb/sv/tb_three_axis_moving_average.sv =====
// testbench top for the three-axis moving-average filter: stimulus, flow control and verdict
module tb_three_axis_moving_average;
    import tam_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 120;
    localparam int CYCLE_LIMIT  = 200000;

    logic clk;
    logic rst_n;

    tam_in_if  samples_ch ();
    tam_out_if averages_ch ();

    int fail_count;
    int pending;
    int checked;

    // module-level state; sent_count and hold_active are shared between sender and receiver processes
    int sent_count  = 0;
    int burst_left  = 0;
    bit hold_active = 1'b0;
    bit hold_done   = 1'b0;
    int cycles      = 0;

    three_axis_moving_average u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples_ch),
        .averages (averages_ch)
    );

    tam_avg_checker u_avg_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples_ch),
        .averages   (averages_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d averages still expected", cycles, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // draws one raw sample; regime 3 leans to positive full scale, regime 4 to negative
    function automatic sample_t pick_sample(input int regime);
        int r;
        r = $urandom_range(0, 9);
        if (regime == 3 && r < 7)
            return sample_t'(32767 - int'($urandom_range(0, 3)));
        if (regime == 4 && r < 7)
            return sample_t'(-32768 + int'($urandom_range(0, 3)));
        case (r)
            0:       return sample_t'(32767);
            1:       return sample_t'(-32768);
            // small values around zero exercise truncation toward zero
            2, 3:    return sample_t'(int'($urandom_range(0, 48)) - 24);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // offers one transaction, with bursts and random gaps between them
    task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz);
        if (burst_left == 0)
        begin
            // no gaps while the output is held off, so the pipeline fills up
            if (!hold_active && $urandom_range(0, 2) != 0)
            begin
                samples_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        samples_ch.valid <= 1'b1;
        samples_ch.x_raw <= sx;
        samples_ch.y_raw <= sy;
        samples_ch.z_raw <= sz;
        // valid was raised at an earlier edge, so ready here completes the transaction
        do
            @(posedge clk);
        while (!samples_ch.ready);
        sent_count++;
    endtask

    // receiver: stall patterns by segment, plus one long hold-off
    initial
    begin
        int mode;
        int seg_left;
        int phase;
        mode = 0;
        seg_left = 0;
        phase = 0;
        averages_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent_count >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_active = 1'b1;
                averages_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 96);
                end
                seg_left--;
                phase++;
                case (mode)
                    0:       averages_ch.ready <= 1'b1;
                    1:       averages_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       averages_ch.ready <= ((phase % 4) != 3);
                    default: averages_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // sender and verdict
    initial
    begin
        int regime;
        rst_n <= 1'b0;
        samples_ch.valid <= 1'b0;
        samples_ch.x_raw <= '0;
        samples_ch.y_raw <= '0;
        samples_ch.z_raw <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window still filling with reset zeros, small negative sums must truncate toward zero
        send_sample(sample_t'(-1), sample_t'(1), sample_t'(-13));
        send_sample(sample_t'(-11), sample_t'(11), sample_t'(-12));
        // full-scale windows on every axis, both signs on x and y
        repeat (12) send_sample(sample_t'(32767), sample_t'(-32768), sample_t'(-32768));
        repeat (11) send_sample(sample_t'(-32768), sample_t'(32767), sample_t'(0));

        regime = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                regime = $urandom_range(0, 4);
            send_sample(pick_sample(regime), pick_sample(regime), pick_sample(regime));
        end
        samples_ch.valid <= 1'b0;

        // let the checker see the last input before looking at what is outstanding
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d samples, checked %0d averages over full-scale and mixed windows",
                 sent_count, checked);
        $display("output held off for %0d cycles once, with burst gaps and stall patterns",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== three_axis_moving_average.f =====
hw/rtl/tam_pkg.sv
hw/rtl/tam_if.sv
hw/rtl/tam_ram.sv
hw/rtl/three_axis_moving_average.sv
tb/sv/tam_avg_checker.sv
tb/sv/tb_three_axis_moving_average.sv
